### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/dbipid_pkg.sv
// ----------------------------------------------------------------------------
// dbipid_pkg
// Types, widths and constants of the deadband incremental PID regulator.
// ----------------------------------------------------------------------------
package dbipid_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DEADBAND    = 30;
    localparam int GAIN_W      = 20;
    localparam int ERR_W       = 9;
    localparam int LIMIT_W     = 9;
    localparam int STEP_LIM_W  = 26;
    localparam int DRIVE_W     = 10;
    localparam int CENT_W      = 8;
    localparam int ACC_W       = DRIVE_W + FRAC_BITS;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = STEP_LIM_W;

    localparam logic [GAIN_W-1:0]     KP_RESET       = GAIN_W'(655);
    localparam logic [GAIN_W-1:0]     KI_RESET       = '0;
    localparam logic [GAIN_W-1:0]     KD_RESET       = '0;
    localparam logic [LIMIT_W-1:0]    INT_LIM_RESET  = '0;
    localparam logic [STEP_LIM_W-1:0] STEP_LIM_RESET = STEP_LIM_W'(1310720);
    localparam logic [DRIVE_W-1:0]    OUT_MAX_RESET  = DRIVE_W'(300);
    localparam logic [DRIVE_W-1:0]    OUT_MIN_RESET  = DRIVE_W'(10);
    localparam logic [CENT_W-1:0]     TARGET_RESET   = CENT_W'(128);
    localparam logic [ACC_W-1:0]      ACC_RESET      = ACC_W'(100) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 4'd0,
        CFG_KI       = 4'd1,
        CFG_KD       = 4'd2,
        CFG_INT_LIM  = 4'd3,
        CFG_STEP_LIM = 4'd4,
        CFG_OUT_MAX  = 4'd5,
        CFG_OUT_MIN  = 4'd6,
        CFG_TARGET   = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0]       int_lim;
        logic [STEP_LIM_W-1:0]    step_lim;
        logic [DRIVE_W-1:0]       out_max;
        logic [DRIVE_W-1:0]       out_min;
        logic [CENT_W-1:0]        target;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
        logic [ACC_W-1:0]        acc;
    } t_pid_state;

endpackage

### rtl/dbipid_step.sv
// ----------------------------------------------------------------------------
// dbipid_step
// One controller update: deadband error, incremental PID step, step clip and
// output clamp, or a preset load.
// ----------------------------------------------------------------------------
module dbipid_step
    import dbipid_pkg::*;
(
    input  logic               i_kind,
    input  logic [CENT_W-1:0]  i_centroid,
    input  logic [DRIVE_W-1:0] i_preset,
    input  t_cfg               i_cfg,
    input  t_pid_state         i_state,
    output t_pid_state         o_state
);

    logic signed [CENT_W+1:0]      w_diff;
    logic signed [ERR_W-1:0]       w_err;
    logic signed [ERR_W:0]         w_d1;
    logic signed [ERR_W+1:0]       w_d2;
    logic [ERR_W-1:0]              w_mag;
    logic                          w_use_i;
    logic signed [GAIN_W+ERR_W:0]  w_prod_p;
    logic signed [GAIN_W+ERR_W+1:0] w_prod_d;
    logic signed [GAIN_W+ERR_W-1:0] w_prod_i;
    logic signed [31:0]            w_step;
    logic [31:0]                   w_step_abs;
    logic signed [STEP_LIM_W:0]    w_step_clip;
    logic signed [ACC_W+2:0]       w_sum;
    logic [ACC_W-1:0]              w_hi;
    logic [ACC_W-1:0]              w_lo;
    logic [ACC_W-1:0]              w_acc;

    assign w_diff = $signed({2'b00, i_cfg.target}) - $signed({2'b00, i_centroid});

    always_comb begin
        if (w_diff <= (CENT_W+2)'(DEADBAND) && w_diff >= -(CENT_W+2)'(DEADBAND)) begin
            w_err = '0;
        end else if (w_diff > 0) begin
            w_err = ERR_W'(w_diff - (CENT_W+2)'(DEADBAND));
        end else begin
            w_err = ERR_W'(w_diff + (CENT_W+2)'(DEADBAND));
        end
    end

    assign w_d1 = (ERR_W+1)'(w_err) - (ERR_W+1)'(i_state.e0);
    assign w_d2 = (ERR_W+2)'(w_err) + (ERR_W+2)'(i_state.e1)
                - ((ERR_W+2)'(i_state.e0) <<< 1);
    assign w_mag   = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);
    assign w_use_i = w_mag < i_cfg.int_lim;

    assign w_prod_p = (GAIN_W+ERR_W+1)'(i_cfg.kp) * (GAIN_W+ERR_W+1)'(w_d1);
    assign w_prod_d = (GAIN_W+ERR_W+2)'(i_cfg.kd) * (GAIN_W+ERR_W+2)'(w_d2);
    assign w_prod_i = (GAIN_W+ERR_W)'(i_cfg.ki) * (GAIN_W+ERR_W)'(w_err);

    assign w_step = 32'(w_prod_p) + 32'(w_prod_d) + (w_use_i ? 32'(w_prod_i) : 32'sd0);
    assign w_step_abs = w_step[31] ? 32'(-w_step) : 32'(w_step);

    always_comb begin
        if (w_step_abs < {{(32-STEP_LIM_W){1'b0}}, i_cfg.step_lim}) begin
            w_step_clip = (STEP_LIM_W+1)'(w_step);
        end else if (w_step > 0) begin
            w_step_clip = $signed({1'b0, i_cfg.step_lim});
        end else if (w_step < 0) begin
            w_step_clip = -$signed({1'b0, i_cfg.step_lim});
        end else begin
            w_step_clip = '0;
        end
    end

    assign w_sum = $signed({3'b000, i_state.acc}) + (ACC_W+3)'(w_step_clip);
    assign w_hi  = {i_cfg.out_max, {FRAC_BITS{1'b0}}};
    assign w_lo  = {i_cfg.out_min, {FRAC_BITS{1'b0}}};

    always_comb begin
        if (w_sum > $signed({3'b000, w_hi})) begin
            w_acc = w_hi;
        end else if (w_sum < $signed({3'b000, w_lo})) begin
            w_acc = w_lo;
        end else begin
            w_acc = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        if (i_kind) begin
            o_state.e0  = '0;
            o_state.e1  = '0;
            o_state.e2  = '0;
            o_state.acc = {i_preset, {FRAC_BITS{1'b0}}};
        end else begin
            o_state.e0  = w_err;
            o_state.e1  = i_state.e0;
            o_state.e2  = i_state.e1;
            o_state.acc = w_acc;
        end
    end

endmodule

### rtl/deadband_incremental_pid.sv
// ----------------------------------------------------------------------------
// deadband_incremental_pid
// Per-frame exposure regulator: deadband error, incremental PID, clipped step
// and clamped drive value, with a preset that reloads the output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: centroid, preset;
//                                                     tuser: kind
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: drive_value
//  cfg       in         i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
//  One word per cycle sustained while the result is not stalled: one input
//  register, then the single-pass update into the result register, which
//  also commits the error history and accumulator.
//  Reset clears both stages and loads register and state reset values.
//  A stalled result holds the update stage; the input register still takes
//  one more word.
// ----------------------------------------------------------------------------
module deadband_incremental_pid
    import dbipid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,   // centroid[7:0], preset_value[17:8]
    input  logic [0:0]            i_s_axis_tuser,   // kind[0]

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // drive_value[9:0]

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic               r_in_kind;
    logic [CENT_W-1:0]  r_in_centroid;
    logic [DRIVE_W-1:0] r_in_preset;
    logic               r_out_valid;
    logic [DRIVE_W-1:0] r_out_drive;
    t_cfg               r_cfg;
    t_pid_state         r_state;
    t_pid_state         n_state;
    logic               w_in_acc;
    logic               w_advance;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    dbipid_step u_step (
        .i_kind     (r_in_kind),
        .i_centroid (r_in_centroid),
        .i_preset   (r_in_preset),
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .o_state    (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.e0  <= '0;
            r_state.e1  <= '0;
            r_state.e2  <= '0;
            r_state.acc <= ACC_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_kind     <= i_s_axis_tuser[0];
            r_in_centroid <= i_s_axis_tdata[CENT_W-1:0];
            r_in_preset   <= i_s_axis_tdata[CENT_W+DRIVE_W-1:CENT_W];
        end
        if (w_advance) begin
            r_out_drive <= n_state.acc[ACC_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp       <= KP_RESET;
            r_cfg.ki       <= KI_RESET;
            r_cfg.kd       <= KD_RESET;
            r_cfg.int_lim  <= INT_LIM_RESET;
            r_cfg.step_lim <= STEP_LIM_RESET;
            r_cfg.out_max  <= OUT_MAX_RESET;
            r_cfg.out_min  <= OUT_MIN_RESET;
            r_cfg.target   <= TARGET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KP:       r_cfg.kp       <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:       r_cfg.ki       <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:       r_cfg.kd       <= i_cfg_data[GAIN_W-1:0];
                CFG_INT_LIM:  r_cfg.int_lim  <= i_cfg_data[LIMIT_W-1:0];
                CFG_STEP_LIM: r_cfg.step_lim <= i_cfg_data[STEP_LIM_W-1:0];
                CFG_OUT_MAX:  r_cfg.out_max  <= i_cfg_data[DRIVE_W-1:0];
                CFG_OUT_MIN:  r_cfg.out_min  <= i_cfg_data[DRIVE_W-1:0];
                CFG_TARGET:   r_cfg.target   <= i_cfg_data[CENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(16-DRIVE_W)'(0), r_out_drive};

endmodule

### rtl/dbipid_checker.sv
// ----------------------------------------------------------------------------
// dbipid_checker
// Port-level checks of the deadband incremental PID regulator, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbipid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic       w_in_acc;
    logic       w_out_stall;
    logic       w_quiet_preset;
    logic       w_preset_out;
    logic       r_idle;
    logic [9:0] r_preset_d1;
    logic [9:0] r_preset_d2;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        r_idle      <= !w_in_acc && !o_m_axis_tvalid;
        r_preset_d1 <= i_s_axis_tdata[17:8];
        r_preset_d2 <= r_preset_d1;
    end

    assign w_quiet_preset = w_in_acc && i_s_axis_tuser[0] && !o_m_axis_tvalid && r_idle;
    assign w_preset_out   = o_m_axis_tvalid && (o_m_axis_tdata[9:0] == r_preset_d2);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    `ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[15:10] == 6'd0)
    `ASSERT_IMP(a_preset_pass, i_clk, i_rst_n, w_quiet_preset, ##2 w_preset_out)

endmodule

bind deadband_incremental_pid dbipid_checker u_dbipid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
